>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  // Port widths fixed by the interface
  localparam int IN_W          = 32;
  localparam int KIND_W        = 3;
  localparam int RES_NUM_W     = 64;
  localparam int RES_DEN_W     = 63;
  localparam int DEF_OPERAND_W = 32;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RECIP = 3'd5;

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Saturation limits on the result
  localparam logic [RES_NUM_W-1:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [RES_NUM_W-1:0] DEN_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

  // Divider request and response
  typedef struct packed {
    logic go;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

>>> hw/rtl/rau_div.sv
`timescale 1ns / 1ps
module rau_div #(
  parameter int DW = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::div_req_t  req,
  input  logic [DW-1:0]      dividend,
  input  logic [DW-1:0]      divisor,
  output rau_pkg::div_rsp_t  rsp,
  output logic [DW-1:0]      quot,
  output logic [DW-1:0]      rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic [DW-1:0] q_r, r_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  // One quotient bit per cycle, restoring
  assign shifted = {r_r, q_r[DW-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r   <= dividend;
        r_r   <= '0;
        d_r   <= divisor;
      end else if (run_r) begin
        if (!trial[DW]) begin
          r_r <= trial[DW-1:0];
          q_r <= {q_r[DW-2:0], 1'b1};
        end else begin
          r_r <= shifted[DW-1:0];
          q_r <= {q_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign quot     = q_r;
  assign rem      = r_r;

endmodule

>>> hw/rtl/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer
// command   in         start & !busy; in_kind, in_a_num, in_a_den, in_b_num, in_b_den
// result    out        out_valid strobe, one cycle; out_res_num, out_res_den, out_status
//
// Reciprocal and unused codes: the result strobe is registered at the transfer and comes in the cycle after it.
// Others: multiply steps (3 add/sub, 2 mul/div, 0 reduce), a sum step, k Euclid steps and 2
// final divisions (numerator, then denominator), each a divider pass; a zero denominator
// at the sum step ends the item there with an error result.
// busy: high for a whole item, low for reciprocal/unused; the receiver cannot stall results.
// Synchronous active-low reset clears the sequencer and the strobe.
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rau_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [rau_pkg::IN_W-1:0]     in_a_num,
  input  logic signed [rau_pkg::IN_W-1:0]     in_a_den,
  input  logic signed [rau_pkg::IN_W-1:0]     in_b_num,
  input  logic signed [rau_pkg::IN_W-1:0]     in_b_den,
  output logic                                out_valid,
  output logic signed [rau_pkg::RES_NUM_W-1:0] out_res_num,
  output logic signed [rau_pkg::RES_DEN_W-1:0] out_res_den,
  output logic                                out_status
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SUM  = 6'b000100,
    S_GCD  = 6'b001000,
    S_DIVN = 6'b010000,
    S_DIVD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Operands in flight
  logic [KIND_W-1:0] kind_r;
  logic [W-1:0]      an_r, ad_r, bn_r, bd_r;
  logic [1:0]        step_r;
  logic [DW-1:0]     p_mag_r [3];
  logic              p_neg_r [3];
  logic [DW-1:0]     num_mag_r, den_mag_r, x_r, y_r, n_r;
  logic              neg_r;
  logic              div_run_r;

  logic              accept;
  assign accept = start && !busy;

  logic [W-1:0] an_in, ad_in;
  assign an_in = in_a_num[W-1:0];
  assign ad_in = in_a_den[W-1:0];

  // Shared multiplier operand select
  logic [W-1:0]  mx, my;
  logic [DW-1:0] prod;
  logic          pneg;
  always_comb begin
    case (step_r)
      2'd0: begin
        mx = an_r;
        my = (kind_r == KIND_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = ad_r;
        my = (kind_r == KIND_MUL) ? bd_r : bn_r;
      end
      default: begin
        mx = ad_r;
        my = bd_r;
      end
    endcase
  end
  assign prod = {{W{1'b0}}, mag_of(mx)} * {{W{1'b0}}, mag_of(my)};
  assign pneg = (prod != '0) && (mx[W-1] != my[W-1]);

  logic last_mul;
  assign last_mul = ((kind_r == KIND_ADD) || (kind_r == KIND_SUB)) ? (step_r == 2'd2)
                                                                   : (step_r == 2'd1);

  // Signed-magnitude add of the two cross products
  logic          y_neg, s_neg;
  logic [DW-1:0] s_mag;
  always_comb begin
    y_neg = (kind_r == KIND_SUB) ? (p_neg_r[1] ^ (p_mag_r[1] != '0)) : p_neg_r[1];
    if (p_neg_r[0] == y_neg) begin
      s_mag = p_mag_r[0] + p_mag_r[1];
      s_neg = p_neg_r[0];
    end else if (p_mag_r[0] >= p_mag_r[1]) begin
      s_mag = p_mag_r[0] - p_mag_r[1];
      s_neg = p_neg_r[0];
    end else begin
      s_mag = p_mag_r[1] - p_mag_r[0];
      s_neg = y_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  logic          is_sum;
  logic [DW-1:0] num_sel, den_sel;
  logic          num_neg_sel, den_neg_sel;
  assign is_sum      = (kind_r == KIND_ADD) || (kind_r == KIND_SUB);
  assign num_sel     = is_sum ? s_mag : p_mag_r[0];
  assign num_neg_sel = is_sum ? s_neg : p_neg_r[0];
  assign den_sel     = is_sum ? p_mag_r[2] : p_mag_r[1];
  assign den_neg_sel = is_sum ? p_neg_r[2] : p_neg_r[1];

  // Shared divider
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic [DW-1:0] dvd, dvs, quot, rem;
  always_comb begin
    case (state_r)
      S_DIVN:  begin dvd = num_mag_r; dvs = x_r; end
      S_DIVD:  begin dvd = den_mag_r; dvs = x_r; end
      default: begin dvd = x_r;       dvs = y_r; end
    endcase
  end
  assign dreq.go = !div_run_r &&
                   (((state_r == S_GCD) && (y_r != '0)) ||
                    (state_r == S_DIVN) || (state_r == S_DIVD));

  rau_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .dividend (dvd),
    .divisor  (dvs),
    .rsp      (drsp),
    .quot     (quot),
    .rem      (rem)
  );

  // Final sign, saturation
  logic [RES_NUM_W-1:0] n64, d64, num_fin, den_fin;
  assign n64     = RES_NUM_W'(n_r);
  assign d64     = RES_NUM_W'(quot);
  assign den_fin = (d64 > DEN_MAX) ? DEN_MAX : d64;
  assign num_fin = (neg_r && (n64 != '0)) ? (~n64 + 1'b1)
                                          : ((n64 > NUM_MAX) ? NUM_MAX : n64);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_RED) state_nxt = S_SUM;
          else if (in_kind < KIND_RED) state_nxt = S_MUL;
        end
      end
      S_MUL:   if (last_mul) state_nxt = S_SUM;
      S_SUM:   state_nxt = (den_sel == '0) ? S_IDLE : S_GCD;
      S_GCD: begin
        if (y_r == '0) state_nxt = S_DIVN;
      end
      S_DIVN:  if (drsp.done) state_nxt = S_DIVD;
      S_DIVD:  if (drsp.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      div_run_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (dreq.go) div_run_r <= 1'b1;
      else if (drsp.done) div_run_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r <= in_kind;
            an_r   <= an_in;
            ad_r   <= ad_in;
            bn_r   <= in_b_num[W-1:0];
            bd_r   <= in_b_den[W-1:0];
            step_r <= 2'd0;
            // reduce: operands go straight to the sum stage
            p_mag_r[0] <= DW'(mag_of(an_in));
            p_neg_r[0] <= an_in[W-1];
            p_mag_r[1] <= DW'(mag_of(ad_in));
            p_neg_r[1] <= ad_in[W-1];
            if (in_kind == KIND_RECIP) begin
              out_valid <= 1'b1;
              if (an_in == '0) begin
                out_res_num <= '0;
                out_res_den <= '0;
                out_status  <= ST_ERR;
              end else begin
                out_res_num <= RES_NUM_W'(signed'(ad_in));
                out_res_den <= RES_DEN_W'(signed'(an_in));
                out_status  <= ST_OK;
              end
            end else if (in_kind > KIND_RECIP) begin
              out_valid   <= 1'b1;
              out_res_num <= '0;
              out_res_den <= '0;
              out_status  <= ST_ERR;
            end
          end
        end
        S_MUL: begin
          p_mag_r[step_r] <= prod;
          p_neg_r[step_r] <= pneg;
          step_r          <= step_r + 1'b1;
        end
        S_SUM: begin
          num_mag_r <= num_sel;
          den_mag_r <= den_sel;
          neg_r     <= num_neg_sel ^ den_neg_sel;
          x_r       <= num_sel;
          y_r       <= den_sel;
          if (den_sel == '0) begin
            out_valid   <= 1'b1;
            out_res_num <= '0;
            out_res_den <= '0;
            out_status  <= ST_ERR;
          end
        end
        S_GCD: begin
          if (drsp.done) begin
            x_r <= y_r;
            y_r <= rem;
          end
        end
        S_DIVN: if (drsp.done) n_r <= quot;
        S_DIVD: begin
          if (drsp.done) begin
            out_valid   <= 1'b1;
            out_res_num <= num_fin;
            out_res_den <= den_fin[RES_DEN_W-1:0];
            out_status  <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  // A result comes only from work under way or a transfer just taken
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a command");

  // Error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ERR)) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("error result with nonzero fields");

  // A reduced good result has a nonzero denominator
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK) && (kind_r != KIND_RECIP)) |-> (out_res_den != '0))
    else $error("reduced result with zero denominator");

endmodule
